[rtl/core/lprt_pkg.sv]
// Package for the IPv4 longest-prefix route table core.
// Holds table sizing, request/status codes, the route entry type and state encoding.
// No dependencies.
package lprt_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int MAX_LEN       = 32;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOROUTE = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  len;
        logic [31:0] gateway;
        logic [7:0]  iface;
    } t_route;

    localparam int ROUTE_W = $bits(t_route);

    // leading-ones mask for a clamped length of 0..32
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        len_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

[rtl/core/ipv4_longest_prefix_route_table_core.sv]
// IPv4 longest-prefix route table: lookup, add and remove over a scanned entry RAM.
// Depends on lprt_pkg and lprt_ram.
// An accepted request steps through the scan, drain and done states with busy high; o_valid follows done.
// Each request does one RAM read per entry, then a write-back for an add that finds a slot.
// Reset (synchronous, active low) empties every slot via per-entry occupancy flops.
// The result is strobed for one cycle on o_valid; the receiver cannot stall.
module ipv4_longest_prefix_route_table_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_req_type,
    input  logic [31:0]           i_address,
    input  logic [5:0]            i_prefix_len,
    input  logic [31:0]           i_next_hop_in,
    input  logic [7:0]            i_iface_in,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [31:0]           o_out_next_hop,
    output logic [7:0]            o_out_iface,
    output logic [31:0]           o_out_prefix,
    output logic [5:0]            o_out_prefix_len
);
    import lprt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;

    // control
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_ev_vld, n_ev_vld;
    logic [IDX_W-1:0] r_ev_idx, n_ev_idx;
    logic             r_hit, n_hit;
    logic             r_ex_hit, n_ex_hit;
    logic             r_free_hit, n_free_hit;
    logic             r_valid_o, n_valid_o;
    logic [TABLE_ENTRIES-1:0] r_occ, n_occ;

    // payload
    logic [1:0]       r_req, n_req;
    logic [31:0]      r_addr, n_addr;
    logic [5:0]       r_len, n_len;
    logic [31:0]      r_nh, n_nh;
    logic [7:0]       r_ifc, n_ifc;
    t_route           r_best, n_best;
    logic [IDX_W-1:0] r_ex_idx, n_ex_idx;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    logic [1:0]       r_o_status, n_o_status;
    t_route           r_o_route, n_o_route;

    // RAM interface
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr;
    t_route           ram_wdata, ram_rdata;
    logic [ROUTE_W-1:0] ram_rbits;

    logic             ev_occ, ev_match, ev_exact;

    lprt_ram #(
        .DATA_W (ROUTE_W),
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = t_route'(ram_rbits);

    assign ev_occ   = r_occ[r_ev_idx];
    assign ev_match = ((ram_rdata.prefix ^ r_addr) & len_mask(ram_rdata.len)) == 32'd0;
    assign ev_exact = ev_occ && (ram_rdata.len == r_len) && (ram_rdata.prefix == r_addr);

    always_comb begin
        n_state    = r_state;
        n_rd_idx   = r_rd_idx;
        n_ev_vld   = 1'b0;
        n_ev_idx   = r_ev_idx;
        n_hit      = r_hit;
        n_ex_hit   = r_ex_hit;
        n_free_hit = r_free_hit;
        n_valid_o  = 1'b0;
        n_occ      = r_occ;
        n_req      = r_req;
        n_addr     = r_addr;
        n_len      = r_len;
        n_nh       = r_nh;
        n_ifc      = r_ifc;
        n_best     = r_best;
        n_ex_idx   = r_ex_idx;
        n_free_idx = r_free_idx;
        n_o_status = r_o_status;
        n_o_route  = r_o_route;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_ex_idx;
        ram_wdata  = '{prefix: r_addr, len: r_len, gateway: r_nh, iface: r_ifc};

        // entry evaluation, one per cycle behind the read
        if (r_ev_vld) begin
            if (ev_occ && ev_match && (!r_hit || (ram_rdata.len > r_best.len))) begin
                n_hit  = 1'b1;
                n_best = ram_rdata;
            end
            if (ev_exact && !r_ex_hit) begin
                n_ex_hit = 1'b1;
                n_ex_idx = r_ev_idx;
            end
            if (!ev_occ && !r_free_hit) begin
                n_free_hit = 1'b1;
                n_free_idx = r_ev_idx;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req      = i_req_type;
                    n_addr     = i_address;
                    n_len      = (i_prefix_len > 6'(MAX_LEN)) ? 6'(MAX_LEN) : i_prefix_len;
                    n_nh       = i_next_hop_in;
                    n_ifc      = i_iface_in;
                    n_rd_idx   = '0;
                    n_hit      = 1'b0;
                    n_ex_hit   = 1'b0;
                    n_free_hit = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                ram_re   = 1'b1;
                n_ev_vld = 1'b1;
                n_ev_idx = r_rd_idx;
                if (r_rd_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_valid_o  = 1'b1;
                n_o_status = ST_OK;
                n_o_route  = '0;
                case (r_req)
                    REQ_LOOKUP: begin
                        if (r_hit) begin
                            n_o_route = r_best;
                        end else begin
                            n_o_status = ST_NOROUTE;
                        end
                    end
                    REQ_ADD: begin
                        if (r_ex_hit || r_free_hit) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_ex_hit ? r_ex_idx : r_free_idx;
                            n_occ[ram_waddr] = (r_ifc != 8'd0);
                        end else begin
                            n_o_status = ST_FULL;
                        end
                    end
                    REQ_REMOVE: begin
                        if (r_ex_hit) begin
                            n_occ[r_ex_idx] = 1'b0;
                        end else begin
                            n_o_status = ST_NOROUTE;
                        end
                    end
                    default: begin
                    end
                endcase
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_idx   <= '0;
            r_ev_vld   <= 1'b0;
            r_ev_idx   <= '0;
            r_hit      <= 1'b0;
            r_ex_hit   <= 1'b0;
            r_free_hit <= 1'b0;
            r_valid_o  <= 1'b0;
            r_occ      <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_idx   <= n_rd_idx;
            r_ev_vld   <= n_ev_vld;
            r_ev_idx   <= n_ev_idx;
            r_hit      <= n_hit;
            r_ex_hit   <= n_ex_hit;
            r_free_hit <= n_free_hit;
            r_valid_o  <= n_valid_o;
            r_occ      <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_len      <= n_len;
        r_nh       <= n_nh;
        r_ifc      <= n_ifc;
        r_best     <= n_best;
        r_ex_idx   <= n_ex_idx;
        r_free_idx <= n_free_idx;
        r_o_status <= n_o_status;
        r_o_route  <= n_o_route;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid_o;
    assign o_status         = r_o_status;
    assign o_out_next_hop   = r_o_route.gateway;
    assign o_out_iface      = r_o_route.iface;
    assign o_out_prefix     = r_o_route.prefix;
    assign o_out_prefix_len = r_o_route.len;

    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_DONE))
        else $error("result strobe without completed scan");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_SCAN && r_rd_idx == '0))
        else $error("accepted request did not start scan at entry zero");

    a_eval_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("entry evaluation outside scan");

    a_hit_fields_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_iface != 8'd0) |-> (o_status == ST_OK))
        else $error("route returned with failing status");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> !ram_we)
        else $error("entry write overlaps scan read");

endmodule

[rtl/core/lprt_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; used for the route entry store. No package dependency.
module lprt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
